FILE: design/srctok_pkg.sv
// Package: token kinds, scan modes and result record for the source tokenizer.
`timescale 1ns / 1ps
package srctok_pkg;

    localparam int KEYWORD_MAX = 8;

    localparam logic [4:0] K_EOF           = 5'd0;
    localparam logic [4:0] K_ERROR         = 5'd1;
    localparam logic [4:0] K_IDENT         = 5'd2;
    localparam logic [4:0] K_NUMBER        = 5'd3;
    localparam logic [4:0] K_STRING        = 5'd4;
    localparam logic [4:0] K_LET           = 5'd5;
    localparam logic [4:0] K_FUNCTION      = 5'd6;
    localparam logic [4:0] K_IF            = 5'd7;
    localparam logic [4:0] K_ELSE          = 5'd8;
    localparam logic [4:0] K_WHILE         = 5'd9;
    localparam logic [4:0] K_RETURN        = 5'd10;
    localparam logic [4:0] K_PLUS          = 5'd11;
    localparam logic [4:0] K_MINUS         = 5'd12;
    localparam logic [4:0] K_STAR          = 5'd13;
    localparam logic [4:0] K_SLASH         = 5'd14;
    localparam logic [4:0] K_EQUAL         = 5'd15;
    localparam logic [4:0] K_BANG          = 5'd17;
    localparam logic [4:0] K_LESS          = 5'd19;
    localparam logic [4:0] K_GREATER       = 5'd21;
    localparam logic [4:0] K_LPAREN        = 5'd23;
    localparam logic [4:0] K_RPAREN        = 5'd24;
    localparam logic [4:0] K_LBRACE        = 5'd25;
    localparam logic [4:0] K_RBRACE        = 5'd26;
    localparam logic [4:0] K_COMMA         = 5'd27;
    localparam logic [4:0] K_SEMICOLON     = 5'd28;

    localparam logic [1:0] C_NONE          = 2'd0;
    localparam logic [1:0] C_UNEXPECTED    = 2'd1;
    localparam logic [1:0] C_UNTERMINATED  = 2'd2;

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_IDENT    = 4'd1;
    localparam logic [3:0] M_NUMBER   = 4'd2;
    localparam logic [3:0] M_NUMDOT   = 4'd3;
    localparam logic [3:0] M_FRACTION = 4'd4;
    localparam logic [3:0] M_STRING   = 4'd5;
    localparam logic [3:0] M_SLASH    = 4'd6;
    localparam logic [3:0] M_COMMENT  = 4'd7;
    localparam logic [3:0] M_BANG     = 4'd8;
    localparam logic [3:0] M_EQUAL    = 4'd9;
    localparam logic [3:0] M_LESS     = 4'd10;
    localparam logic [3:0] M_GREATER  = 4'd11;

    typedef struct packed {
        logic        last;
        logic [15:0] length;
        logic [15:0] column;
        logic [15:0] line;
        logic [1:0]  cause;
        logic [4:0]  kind;
    } t_tok;

    // first eight identifier bytes, byte 0 in the low bits
    function automatic logic [4:0] keyword_kind(input logic [63:0] p, input logic [3:0] len);
        logic [4:0] k;
        k = K_IDENT;
        if (len == 4'd3 && p[23:0] == "tel") k = K_LET;
        if (len == 4'd8 && p[63:0] == "noitcnuf") k = K_FUNCTION;
        if (len == 4'd2 && p[15:0] == "fi") k = K_IF;
        if (len == 4'd4 && p[31:0] == "esle") k = K_ELSE;
        if (len == 4'd5 && p[39:0] == "elihw") k = K_WHILE;
        if (len == 4'd6 && p[47:0] == "nruter") k = K_RETURN;
        return k;
    endfunction

endpackage

FILE: design/source_tokenizer_unit.sv
// Top level: streaming tokenizer, one source byte per transaction in, tokens out.
//
// Input channel: one transaction per source byte (tuser = 1 or byte 0 means
// end of input). Output channel: one transaction per token; tlast marks the
// final token caused by one input transaction.
// Each input byte is scanned in the cycle it is accepted; the tokens it
// completes (up to three) are written into an 8-entry output queue in that
// same cycle. Sustained rate is one byte per cycle while the queue has room;
// the queue drains one token a cycle while the receiver is ready, so a byte
// that completes two or three tokens holds off input only when the queue
// fills. Input ready is high while the queue has room for three tokens.
// Reset clears the queue and returns the scanner to line 1, column 1.
// When the receiver stalls, the head token is held and the queue fills;
// input is then held off until space frees.
// End of input flushes any pending token (an unterminated error for an open
// string), emits EOF, and scanning resumes as a continuation, line and column kept.
`timescale 1ns / 1ps
module source_tokenizer_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // char_code[7:0]
    input  logic        i_s_tuser,   // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // token_kind[4:0], error_cause[6:5], start_line[22:7],
                                     // start_column[38:23], token_length[54:39], zero[55]
    output logic        o_m_tlast    // last
);
    import srctok_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam int KW = $clog2(KEYWORD_MAX);
    localparam int QD = 8;
    localparam int QA = 3;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v != CMAX) ? v + ONE : v;
    endfunction

    function automatic logic [15:0] to16(input logic [CW-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[15:0];
    endfunction

    function automatic t_tok mk(input logic [4:0] k, input logic [1:0] c,
                                input logic [CW-1:0] l, input logic [CW-1:0] col,
                                input logic [CW-1:0] len);
        t_tok t;
        t.kind = k;
        t.cause = c;
        t.line = to16(l);
        t.column = to16(col);
        t.length = to16(len);
        t.last = 1'b0;
        return t;
    endfunction

    logic [3:0]    r_mode, n_mode;
    logic [CW-1:0] r_cur_line, n_cur_line, r_cur_col, n_cur_col;
    logic [CW-1:0] r_tok_line, n_tok_line, r_tok_col, n_tok_col, r_tok_len, n_tok_len;
    logic [7:0]    r_pre [KEYWORD_MAX];
    logic [7:0]    n_pre [KEYWORD_MAX];

    t_tok          r_q [QD];
    logic [QA-1:0] r_wr, r_rd;
    logic [QA:0]   r_count;

    t_tok          e [3];
    logic [1:0]    ne;
    logic          acc, pop;

    assign acc = i_s_tvalid && o_s_tready;
    assign pop = o_m_tvalid && i_m_tready;
    assign o_s_tready = r_count <= (QA+1)'(QD - 3);
    assign o_m_tvalid = r_count != '0;
    assign o_m_tdata = {1'b0, r_q[r_rd].length, r_q[r_rd].column, r_q[r_rd].line,
                        r_q[r_rd].cause, r_q[r_rd].kind};
    assign o_m_tlast = r_q[r_rd].last;

    always_comb begin
        logic [7:0]    c;
        logic          fin, used, alpha, digit;
        logic [4:0]    single, opk;
        logic [63:0]   pv;
        logic [31:0]   lw;
        c = i_s_tdata;
        fin = i_s_tuser || (c == 8'd0);
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        digit = c >= "0" && c <= "9";
        used = 1'b0;
        single = K_EOF;
        opk = K_BANG;
        pv = '0;
        lw = 32'(r_tok_len);
        n_mode = r_mode;
        n_cur_line = r_cur_line;
        n_cur_col = r_cur_col;
        n_tok_line = r_tok_line;
        n_tok_col = r_tok_col;
        n_tok_len = r_tok_len;
        n_pre = r_pre;
        ne = 2'd0;
        for (int i = 0; i < 3; i++) e[i] = mk(K_EOF, C_NONE, '0, '0, '0);
        for (int i = 0; i < 8; i++) pv[i*8 +: 8] = r_pre[i];

        case (r_mode)
            M_IDLE: begin
            end
            M_IDENT: begin
                if (!fin && (alpha || digit)) begin
                    if (lw < 32'(KEYWORD_MAX)) n_pre[r_tok_len[KW-1:0]] = c;
                    n_tok_len = sat_inc(r_tok_len);
                    n_cur_col = sat_inc(r_cur_col);
                    used = 1'b1;
                end else begin
                    e[ne] = mk((lw > 32'(KEYWORD_MAX)) ? K_IDENT : keyword_kind(pv, lw[3:0]),
                               C_NONE, r_tok_line, r_tok_col, r_tok_len);
                    ne = ne + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_NUMBER, M_FRACTION: begin
                if (!fin && digit) begin
                    n_tok_len = sat_inc(r_tok_len);
                    n_cur_col = sat_inc(r_cur_col);
                    used = 1'b1;
                end else if (!fin && c == "." && r_mode == M_NUMBER) begin
                    n_cur_col = sat_inc(r_cur_col);
                    n_mode = M_NUMDOT;
                    used = 1'b1;
                end else begin
                    e[ne] = mk(K_NUMBER, C_NONE, r_tok_line, r_tok_col, r_tok_len);
                    ne = ne + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_NUMDOT: begin
                if (!fin && digit) begin
                    n_tok_len = sat_inc(sat_inc(r_tok_len));
                    n_cur_col = sat_inc(r_cur_col);
                    n_mode = M_FRACTION;
                    used = 1'b1;
                end else begin
                    e[ne] = mk(K_NUMBER, C_NONE, r_tok_line, r_tok_col, r_tok_len);
                    ne = ne + 2'd1;
                    e[ne] = mk(K_ERROR, C_UNEXPECTED, r_cur_line, r_cur_col, '0);
                    ne = ne + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_STRING: begin
                if (fin) begin
                    e[ne] = mk(K_ERROR, C_UNTERMINATED, r_cur_line, r_cur_col, '0);
                    ne = ne + 2'd1;
                    n_mode = M_IDLE;
                end else begin
                    n_tok_len = sat_inc(r_tok_len);
                    if (c == 8'h0A) begin
                        n_cur_line = sat_inc(r_cur_line);
                        n_cur_col = ONE;
                    end else begin
                        n_cur_col = sat_inc(r_cur_col);
                    end
                    if (c == "\"") begin
                        e[ne] = mk(K_STRING, C_NONE, r_tok_line, r_tok_col, n_tok_len);
                        ne = ne + 2'd1;
                        n_mode = M_IDLE;
                    end
                    used = 1'b1;
                end
            end
            M_SLASH: begin
                if (!fin && c == "/") begin
                    n_cur_col = sat_inc(r_cur_col);
                    n_mode = M_COMMENT;
                    used = 1'b1;
                end else begin
                    e[ne] = mk(K_SLASH, C_NONE, r_tok_line, r_tok_col, ONE);
                    ne = ne + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_COMMENT: begin
                if (fin || c == 8'h0A) begin
                    n_mode = M_IDLE;
                end else begin
                    n_cur_col = sat_inc(r_cur_col);
                    used = 1'b1;
                end
            end
            M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
                case (r_mode)
                    M_BANG:  opk = K_BANG;
                    M_EQUAL: opk = K_EQUAL;
                    M_LESS:  opk = K_LESS;
                    default: opk = K_GREATER;
                endcase
                if (!fin && c == "=") begin
                    n_cur_col = sat_inc(r_cur_col);
                    e[ne] = mk(opk + 5'd1, C_NONE, r_tok_line, r_tok_col, CW'(2));
                    used = 1'b1;
                end else begin
                    e[ne] = mk(opk, C_NONE, r_tok_line, r_tok_col, ONE);
                end
                ne = ne + 2'd1;
                n_mode = M_IDLE;
            end
            default: n_mode = M_IDLE;
        endcase

        if (!used) begin
            if (fin) begin
                e[ne] = mk(K_EOF, C_NONE, n_cur_line, n_cur_col, '0);
                ne = ne + 2'd1;
                n_mode = M_IDLE;
            end else if (c == " " || c == 8'h0D || c == 8'h09) begin
                n_cur_col = sat_inc(n_cur_col);
            end else if (c == 8'h0A) begin
                n_cur_line = sat_inc(n_cur_line);
                n_cur_col = ONE;
            end else begin
                case (c)
                    "+": single = K_PLUS;
                    "-": single = K_MINUS;
                    "*": single = K_STAR;
                    "(": single = K_LPAREN;
                    ")": single = K_RPAREN;
                    "{": single = K_LBRACE;
                    "}": single = K_RBRACE;
                    ",": single = K_COMMA;
                    ";": single = K_SEMICOLON;
                    default: single = K_EOF;
                endcase
                if (c == "\"" || c == "/" || c == "!" || c == "=" || c == "<" || c == ">"
                        || single != K_EOF || alpha || digit) begin
                    n_tok_line = n_cur_line;
                    n_tok_col = n_cur_col;
                    n_tok_len = ONE;
                    n_cur_col = sat_inc(n_cur_col);
                    case (c)
                        "\"":    n_mode = M_STRING;
                        "/":     n_mode = M_SLASH;
                        "!":     n_mode = M_BANG;
                        "=":     n_mode = M_EQUAL;
                        "<":     n_mode = M_LESS;
                        ">":     n_mode = M_GREATER;
                        default: n_mode = alpha ? M_IDENT : (digit ? M_NUMBER : M_IDLE);
                    endcase
                    if (alpha) n_pre[0] = c;
                    if (single != K_EOF) begin
                        e[ne] = mk(single, C_NONE, n_tok_line, n_tok_col, ONE);
                        ne = ne + 2'd1;
                    end
                end else begin
                    n_cur_col = sat_inc(n_cur_col);
                    e[ne] = mk(K_ERROR, C_UNEXPECTED, n_cur_line, n_cur_col, '0);
                    ne = ne + 2'd1;
                end
            end
        end
        if (ne != 2'd0) e[ne - 2'd1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cur_line <= ONE;
            r_cur_col <= ONE;
            r_tok_line <= ONE;
            r_tok_col <= ONE;
            r_tok_len <= '0;
            for (int i = 0; i < KEYWORD_MAX; i++) r_pre[i] <= '0;
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (acc) begin
                r_mode <= n_mode;
                r_cur_line <= n_cur_line;
                r_cur_col <= n_cur_col;
                r_tok_line <= n_tok_line;
                r_tok_col <= n_tok_col;
                r_tok_len <= n_tok_len;
                r_pre <= n_pre;
                r_wr <= r_wr + QA'(ne);
            end
            if (pop) r_rd <= r_rd + QA'(1);
            r_count <= r_count + (acc ? (QA+1)'(ne) : '0) - (pop ? (QA+1)'(1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < ne) r_q[r_wr + QA'(i)] <= e[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QA+1)'(QD))
        else $error("token queue overflow");
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> r_count == '0)
        else $error("queue not empty after reset");
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_count <= (QA+1)'(QD - 3))
        else $error("ready without room for three tokens");
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_line != '0 && r_cur_col != '0)
        else $error("line or column reached zero");
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= M_GREATER)
        else $error("scan mode out of range");
`endif

endmodule
